// ----- rtl/pspc_pkg.sv -----
// ----------------------------------------------------------------------------
// pspc_pkg
// Shared constants and payload types of the permutation statistics classifier.
// ----------------------------------------------------------------------------
package pspc_pkg;

    localparam int MAX_LEN = 16;
    localparam int VAL_W   = 5;
    localparam int CNT_W   = $clog2(MAX_LEN + 1);
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int ACC_W   = $clog2(MAX_LEN * (MAX_LEN - 1) / 2 + 1);
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [4:0] value;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [4:0] value;
        logic       last;
        logic       keep;
    } queue_item_t;

    typedef struct packed {
        logic [4:0] length;
        logic [6:0] inversions;
        logic [6:0] major_index;
        logic [3:0] descents;
        logic [2:0] peaks;
        logic [4:0] longest_rise;
        logic       avoids_1234;
        logic       avoids_1342;
        logic       avoids_1324;
        logic       avoids_4321;
        logic       too_long;
    } result_t;

endpackage

// ----- rtl/permutation_stats_pattern_classifier.sv -----
// ----------------------------------------------------------------------------
// permutation_stats_pattern_classifier
// Permutation statistics and pattern-avoidance classifier, top level.
// ----------------------------------------------------------------------------
// Entries enter a two-deep queue and are taken by the engine one at a time.
// A kept entry is taken from the queue; the engine then reads the entries
// already stored through a single port, one entry per cycle, to find the
// rise length and inversion count of the new entry. A dropped entry is taken
// from the queue and not stored. After the last entry, a permutation of n
// entries with n >= 4 is scanned over position pairs for the four patterns,
// then the result register is loaded; shorter permutations go straight to
// the result. The result register frees the engine to start the next
// permutation while the result waits for m_ready.
// ----------------------------------------------------------------------------
module permutation_stats_pattern_classifier (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pspc_pkg::in_item_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output pspc_pkg::result_t  m_data
);

    logic                  q_valid;
    logic                  q_ready;
    pspc_pkg::queue_item_t q_item;

    pspc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    pspc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ----- rtl/pspc_front.sv -----
// ----------------------------------------------------------------------------
// pspc_front
// Input side: tags each entry as kept or dropped and queues it for the engine.
// ----------------------------------------------------------------------------
module pspc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  pspc_pkg::in_item_t    s_data,
    output logic                  q_valid,
    input  logic                  q_ready,
    output pspc_pkg::queue_item_t q_item
);

    pspc_pkg::queue_item_t              mem_reg [pspc_pkg::Q_DEPTH];
    logic [pspc_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [pspc_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [pspc_pkg::QCNT_W-1:0]        fill_reg, fill_next;
    logic [pspc_pkg::CNT_W-1:0]         seen_reg, seen_next;
    logic                               push, pop;
    pspc_pkg::queue_item_t              push_item;

    assign s_ready = (fill_reg != pspc_pkg::QCNT_W'(pspc_pkg::Q_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        push_item.value = s_data.value;
        push_item.last  = s_data.last;
        push_item.keep  = (seen_reg < pspc_pkg::CNT_W'(pspc_pkg::MAX_LEN));
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        seen_next   = seen_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == pspc_pkg::QPTR_W'(pspc_pkg::Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
            if (s_data.last) begin
                seen_next = '0;
            end else if (push_item.keep) begin
                seen_next = seen_reg + 1'b1;
            end
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == pspc_pkg::QPTR_W'(pspc_pkg::Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!push && pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            seen_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            seen_reg   <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/pspc_engine.sv -----
// ----------------------------------------------------------------------------
// pspc_engine
// Back side: stores entries, walks the store per entry for rise length and
// inversions, scans position pairs for the four patterns, holds the result.
// ----------------------------------------------------------------------------
module pspc_engine (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  pspc_pkg::queue_item_t q_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output pspc_pkg::result_t     m_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WALK = 6'b000010,
        ST_INIT = 6'b000100,
        ST_LOAD = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    localparam int CW = pspc_pkg::CNT_W;
    localparam int IW = pspc_pkg::IDX_W;
    localparam int VW = pspc_pkg::VAL_W;
    localparam int AW = pspc_pkg::ACC_W;

    logic [VW-1:0] entry_mem [pspc_pkg::MAX_LEN];
    logic [CW-1:0] rise_mem  [pspc_pkg::MAX_LEN];

    state_t                state_reg, state_next;
    pspc_pkg::queue_item_t item_reg, item_next;
    logic [CW-1:0] j_reg, j_next, best_reg, best_next, gt_reg, gt_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] inv_reg, inv_next, maj_reg, maj_next;
    logic [CW-1:0] des_reg, des_next, pk_reg, pk_next, lis_reg, lis_next;
    logic [VW-1:0] prev1_reg, prev1_next, prev2_reg, prev2_next;
    logic [IW-1:0] x1_reg, x1_next, x2_reg, x2_next;
    logic [VW-1:0] a1_reg, a1_next, pmin_reg, pmin_next, pmax_reg, pmax_next;
    logic [3:0]    hit_reg, hit_next;
    logic          m_valid_reg, m_valid_next;
    pspc_pkg::result_t m_data_reg, m_data_next;

    logic [IW-1:0] rd_idx;
    logic [VW-1:0] rd_entry, v;
    logic [CW-1:0] rd_rise, n_new;
    logic          wr_en, out_load;
    logic          tail_gt_a1, tail_gt_a2, tail_lt_a2, tail_mid;
    logic          tail_ok;

    assign v        = item_reg.value;
    assign rd_entry = entry_mem[rd_idx];
    assign rd_rise  = rise_mem[rd_idx];
    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign n_new    = count_reg + 1'b1;

    always_comb begin
        case (state_reg)
            ST_WALK: rd_idx = j_reg[IW-1:0];
            ST_LOAD: rd_idx = x1_reg;
            ST_SCAN: rd_idx = x2_reg;
            default: rd_idx = '0;
        endcase
    end

    always_comb begin
        tail_gt_a1 = 1'b0;
        tail_gt_a2 = 1'b0;
        tail_lt_a2 = 1'b0;
        tail_mid   = 1'b0;
        tail_ok    = 1'b0;
        for (int l = 0; l < pspc_pkg::MAX_LEN; l++) begin
            tail_ok = (CW'(l) > CW'(x2_reg)) && (CW'(l) < count_reg);
            if (tail_ok && entry_mem[l] > a1_reg) tail_gt_a1 = 1'b1;
            if (tail_ok && entry_mem[l] > rd_entry) tail_gt_a2 = 1'b1;
            if (tail_ok && entry_mem[l] < rd_entry) tail_lt_a2 = 1'b1;
            if (tail_ok && entry_mem[l] > pmin_reg && entry_mem[l] < a1_reg) tail_mid = 1'b1;
        end
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        j_next       = j_reg;
        best_next    = best_reg;
        gt_next      = gt_reg;
        count_next   = count_reg;
        ovf_next     = ovf_reg;
        inv_next     = inv_reg;
        maj_next     = maj_reg;
        des_next     = des_reg;
        pk_next      = pk_reg;
        lis_next     = lis_reg;
        prev1_next   = prev1_reg;
        prev2_next   = prev2_reg;
        x1_next      = x1_reg;
        x2_next      = x2_reg;
        a1_next      = a1_reg;
        pmin_next    = pmin_reg;
        pmax_next    = pmax_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    item_next = q_item;
                    j_next    = '0;
                    best_next = CW'(1);
                    gt_next   = '0;
                    if (q_item.keep) begin
                        state_next = ST_WALK;
                    end else begin
                        ovf_next = 1'b1;
                        if (q_item.last) begin
                            state_next = (count_reg < CW'(4)) ? ST_EMIT : ST_INIT;
                        end
                    end
                end
            end
            ST_WALK: begin
                if (j_reg == count_reg) begin
                    wr_en      = 1'b1;
                    count_next = n_new;
                    inv_next   = inv_reg + AW'(gt_reg);
                    if (count_reg != '0 && prev1_reg > v) begin
                        des_next = des_reg + 1'b1;
                        maj_next = maj_reg + AW'(count_reg);
                    end
                    if (count_reg >= CW'(2) && prev2_reg < prev1_reg && prev1_reg > v) begin
                        pk_next = pk_reg + 1'b1;
                    end
                    if (best_reg > lis_reg) lis_next = best_reg;
                    prev2_next = prev1_reg;
                    prev1_next = v;
                    if (item_reg.last) begin
                        state_next = (n_new < CW'(4)) ? ST_EMIT : ST_INIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else begin
                    if (rd_entry < v && rd_rise + 1'b1 > best_reg) best_next = rd_rise + 1'b1;
                    if (rd_entry > v) gt_next = gt_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
            end
            ST_INIT: begin
                pmin_next  = rd_entry;
                pmax_next  = rd_entry;
                x1_next    = IW'(1);
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                a1_next    = rd_entry;
                x2_next    = x1_reg + 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pmin_reg < a1_reg && a1_reg < rd_entry && tail_gt_a2) hit_next[3] = 1'b1;
                if (a1_reg < rd_entry && tail_mid) hit_next[2] = 1'b1;
                if (rd_entry < a1_reg && pmin_reg < rd_entry && tail_gt_a1) hit_next[1] = 1'b1;
                if (pmax_reg > a1_reg && a1_reg > rd_entry && tail_lt_a2) hit_next[0] = 1'b1;
                if (CW'(x2_reg) == count_reg - CW'(2)) begin
                    if (CW'(x1_reg) == count_reg - CW'(3)) begin
                        state_next = ST_EMIT;
                    end else begin
                        if (a1_reg < pmin_reg) pmin_next = a1_reg;
                        if (a1_reg > pmax_reg) pmax_next = a1_reg;
                        x1_next    = x1_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end else begin
                    x2_next = x2_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load                 = 1'b1;
                    m_valid_next             = 1'b1;
                    m_data_next.length       = 5'(count_reg);
                    m_data_next.inversions   = 7'(inv_reg);
                    m_data_next.major_index  = 7'(maj_reg);
                    m_data_next.descents     = 4'(des_reg);
                    m_data_next.peaks        = 3'(pk_reg);
                    m_data_next.longest_rise = 5'(lis_reg);
                    m_data_next.avoids_1234  = !hit_reg[3];
                    m_data_next.avoids_1342  = !hit_reg[2];
                    m_data_next.avoids_1324  = !hit_reg[1];
                    m_data_next.avoids_4321  = !hit_reg[0];
                    m_data_next.too_long     = ovf_reg;
                    count_next = '0;
                    ovf_next   = 1'b0;
                    inv_next   = '0;
                    maj_next   = '0;
                    des_next   = '0;
                    pk_next    = '0;
                    lis_next   = '0;
                    hit_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            inv_reg     <= '0;
            maj_reg     <= '0;
            des_reg     <= '0;
            pk_reg      <= '0;
            lis_reg     <= '0;
            hit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            inv_reg     <= inv_next;
            maj_reg     <= maj_next;
            des_reg     <= des_next;
            pk_reg      <= pk_next;
            lis_reg     <= lis_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        j_reg      <= j_next;
        best_reg   <= best_next;
        gt_reg     <= gt_next;
        prev1_reg  <= prev1_next;
        prev2_reg  <= prev2_next;
        x1_reg     <= x1_next;
        x2_reg     <= x2_next;
        a1_reg     <= a1_next;
        pmin_reg   <= pmin_next;
        pmax_reg   <= pmax_next;
        m_data_reg <= m_data_next;
        if (wr_en) begin
            entry_mem[count_reg[IW-1:0]] <= v;
            rise_mem[count_reg[IW-1:0]]  <= best_reg;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(pspc_pkg::MAX_LEN))
        else $error("entry count beyond store depth");

    a_scan_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (x1_reg < x2_reg && CW'(x2_reg) < count_reg))
        else $error("pair scan out of order");

    a_rise_vs_1234: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (hit_reg[3] == (lis_reg >= CW'(4))))
        else $error("1234 flag disagrees with longest rise");

    a_drop_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && q_valid && !q_item.keep)
        |-> (count_reg == CW'(pspc_pkg::MAX_LEN)))
        else $error("entry dropped while store has room");

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the permutation statistics classifier: a queue-fed
// burst driver, a stalling result monitor and an in-bench predictor that
// computes statistics and pattern flags for each closed permutation.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    pspc_pkg::in_item_t s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    pspc_pkg::result_t  m_data;

    permutation_stats_pattern_classifier i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    pspc_pkg::in_item_t pending_entries[$];
    pspc_pkg::result_t  expected_stats[$];
    logic [4:0]  perm_vals[pspc_pkg::MAX_LEN];
    logic [4:0]  perm_rise[pspc_pkg::MAX_LEN];
    int          perm_count;
    bit          perm_dropped;
    int          mismatches;
    int          cycle_count;
    bit          stim_done;

    function automatic bit same_dir(int a, int b, int c, int d);
        if (a < b) return c < d;
        if (a > b) return c > d;
        return 1'b0;
    endfunction

    function automatic bit contains_pattern(int p0, int p1, int p2, int p3);
        int pat[4];
        int ix[4];
        bit ok;
        pat = '{p0, p1, p2, p3};
        for (int a = 0; a < perm_count; a++)
            for (int b = a + 1; b < perm_count; b++)
                for (int c = b + 1; c < perm_count; c++)
                    for (int d = c + 1; d < perm_count; d++) begin
                        ix = '{a, b, c, d};
                        ok = 1'b1;
                        for (int x = 0; x < 4; x++)
                            for (int y = x + 1; y < 4; y++)
                                if (!same_dir(perm_vals[ix[x]], perm_vals[ix[y]],
                                              pat[x], pat[y]))
                                    ok = 1'b0;
                        if (ok) return 1'b1;
                    end
        return 1'b0;
    endfunction

    task automatic predict_entry(pspc_pkg::in_item_t it);
        int best;
        int inv, maj, des, pk, lis;
        pspc_pkg::result_t r;
        if (perm_count < pspc_pkg::MAX_LEN) begin
            best = 1;
            for (int j = 0; j < perm_count; j++)
                if (perm_vals[j] < it.value && perm_rise[j] + 1 > best)
                    best = perm_rise[j] + 1;
            perm_vals[perm_count] = it.value;
            perm_rise[perm_count] = best[4:0];
            perm_count++;
        end else begin
            perm_dropped = 1'b1;
        end
        if (!it.last) return;
        inv = 0; maj = 0; des = 0; pk = 0; lis = 0;
        for (int i = 0; i < perm_count; i++) begin
            for (int j = i + 1; j < perm_count; j++)
                if (perm_vals[i] > perm_vals[j]) inv++;
            if (i + 1 < perm_count && perm_vals[i] > perm_vals[i + 1]) begin
                des++;
                maj += i + 1;
            end
            if (i >= 1 && i + 1 < perm_count && perm_vals[i - 1] < perm_vals[i] &&
                perm_vals[i] > perm_vals[i + 1])
                pk++;
            if (perm_rise[i] > lis) lis = perm_rise[i];
        end
        r.length       = perm_count[4:0];
        r.inversions   = inv[6:0];
        r.major_index  = maj[6:0];
        r.descents     = des[3:0];
        r.peaks        = pk[2:0];
        r.longest_rise = lis[4:0];
        r.avoids_1234  = !contains_pattern(1, 2, 3, 4);
        r.avoids_1342  = !contains_pattern(1, 3, 4, 2);
        r.avoids_1324  = !contains_pattern(1, 3, 2, 4);
        r.avoids_4321  = !contains_pattern(4, 3, 2, 1);
        r.too_long     = perm_dropped;
        expected_stats.push_back(r);
        perm_count = 0;
        perm_dropped = 1'b0;
    endtask

    task automatic report_mismatch(string field, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d",
                 field, got, want, cycle_count);
        mismatches++;
    endtask

    task automatic queue_perm(int len, bit shuffled, bit noisy);
        int vals[$];
        int k, t;
        pspc_pkg::in_item_t it;
        for (int i = 1; i <= len; i++) vals.push_back(((i - 1) % 16) + 1);
        if (shuffled)
            for (int i = len - 1; i > 0; i--) begin
                k = $urandom_range(i, 0);
                t = vals[i]; vals[i] = vals[k]; vals[k] = t;
            end
        for (int i = 0; i < len; i++) begin
            it.value = noisy ? 5'($urandom) : 5'(vals[i]);
            it.last  = (i == len - 1);
            pending_entries.push_back(it);
        end
    endtask

    task automatic queue_list(int v[$]);
        pspc_pkg::in_item_t it;
        foreach (v[i]) begin
            it.value = 5'(v[i]);
            it.last  = (i == v.size() - 1);
            pending_entries.push_back(it);
        end
    endtask

    // driver
    int  burst_left;
    int  gap_left;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predict_entry(s_data);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_entries.size() > 0) begin
                    s_data  <= pending_entries.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(20, 1);
                        gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  stall_mode;
    pspc_pkg::result_t want;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_stats.size() == 0) begin
                    report_mismatch("unexpected transfer", 1, 0);
                end else begin
                    want = expected_stats.pop_front();
                    if (m_data.length != want.length)
                        report_mismatch("length", m_data.length, want.length);
                    if (m_data.inversions != want.inversions)
                        report_mismatch("inversions", m_data.inversions, want.inversions);
                    if (m_data.major_index != want.major_index)
                        report_mismatch("major_index", m_data.major_index, want.major_index);
                    if (m_data.descents != want.descents)
                        report_mismatch("descents", m_data.descents, want.descents);
                    if (m_data.peaks != want.peaks)
                        report_mismatch("peaks", m_data.peaks, want.peaks);
                    if (m_data.longest_rise != want.longest_rise)
                        report_mismatch("longest_rise", m_data.longest_rise,
                                        want.longest_rise);
                    if (m_data.avoids_1234 != want.avoids_1234)
                        report_mismatch("avoids_1234", m_data.avoids_1234, want.avoids_1234);
                    if (m_data.avoids_1342 != want.avoids_1342)
                        report_mismatch("avoids_1342", m_data.avoids_1342, want.avoids_1342);
                    if (m_data.avoids_1324 != want.avoids_1324)
                        report_mismatch("avoids_1324", m_data.avoids_1324, want.avoids_1324);
                    if (m_data.avoids_4321 != want.avoids_4321)
                        report_mismatch("avoids_4321", m_data.avoids_4321, want.avoids_4321);
                    if (m_data.too_long != want.too_long)
                        report_mismatch("too_long", m_data.too_long, want.too_long);
                end
            end
            if (cycle_count % 400 == 0) stall_mode <= $urandom_range(3, 0);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(3, 0) != 0);
                2: m_ready <= ($urandom_range(3, 0) == 0);
                default: m_ready <= (cycle_count % 7) < 3;
            endcase
        end
    end

    initial begin
        perm_count = 0;
        perm_dropped = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        stall_mode = 0;
        stim_done = 1'b0;
        queue_list('{1});
        queue_list('{2, 1, 3});
        queue_list('{1, 2, 3, 4});
        queue_list('{4, 3, 2, 1});
        queue_list('{1, 3, 4, 2});
        queue_list('{1, 3, 2, 4});
        queue_list('{3, 3, 0, 31, 31});
        queue_perm(16, 1'b0, 1'b0);
        queue_list('{16, 15, 14, 13, 12, 11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1, 21, 10});
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_entries.size() < 500) begin
            case ($urandom_range(9, 0))
                0: queue_perm($urandom_range(20, 17), 1'b1, 1'b0);
                1: queue_perm($urandom_range(8, 1), 1'b1, 1'b1);
                default: queue_perm($urandom_range(10, 1), 1'b1, 1'b0);
            endcase
        end
        queue_perm(16, 1'b1, 1'b0);
        stim_done = 1'b1;
    end

    initial begin
        wait (aresetn && stim_done && pending_entries.size() == 0 && !s_valid
              && expected_stats.size() == 0);
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("permutation_stats_pattern_classifier verification clean");
        else
            $display("permutation_stats_pattern_classifier verification failed");
        $finish;
    end

    initial begin
        wait (cycle_count >= 400000);
        $display("permutation_stats_pattern_classifier verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/pspc_pkg.sv
rtl/pspc_front.sv
rtl/pspc_engine.sv
rtl/permutation_stats_pattern_classifier.sv
tb/tb.sv
